// ===== rtl/core/dhkv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double hash key/value map.
package dhkv_pkg;

	localparam int unsigned MIN_SIZE = 7;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_OTHER  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_FND  = 2'd1,
		ST_FULL     = 2'd2,
		ST_ZERO_KEY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_USED  = 2'd1,
		TAG_GONE  = 2'd2,
		TAG_RSVD  = 2'd3
	} tag_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_MOD,
		FSM_STEP,
		FSM_READ,
		FSM_CHECK,
		FSM_WRITE,
		FSM_DONE
	} fsm_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic mod_start;
		logic fix_step;
		logic rd;
		logic advance;
		logic decide;
		logic commit;
		logic out_load;
	} dhkv_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_last;
		logic mod_done;
		logic zero_key;
		logic stop;
	} dhkv_sts_t;

endpackage

// ===== rtl/core/dhkv_mod.sv =====
`timescale 1ns / 1ps
// Restoring remainder unit: one quotient bit a cycle.
module dhkv_mod #(
	parameter int unsigned NUM_W = 32,
	parameter int unsigned DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [DEN_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   shifted;

	assign shifted = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};

	// Shift in one numerator bit, subtract when possible
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (shifted >= {1'b0, den}) begin
				rem_q <= shifted - {1'b0, den};
			end else begin
				rem_q <= shifted;
			end
		end
	end

	assign done = !busy_q && !start;
	assign rem  = rem_q[DEN_W-1:0];

endmodule

// ===== rtl/core/dhkv_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the map.
module dhkv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  dhkv_pkg::dhkv_sts_t sts,
	output dhkv_pkg::dhkv_cmd_t cmd,
	output logic               idle
);

	dhkv_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhkv_pkg::FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		idle     = 1'b0;
		case (state_q)
			dhkv_pkg::FSM_CLEAR: begin
				cmd.clear_wr = 1'b1;
				idle         = 1'b1;
				if (sts.clear_last) begin
					state_d = dhkv_pkg::FSM_IDLE;
				end
			end
			dhkv_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				idle     = !out_valid;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = dhkv_pkg::FSM_MOD;
				end
			end
			dhkv_pkg::FSM_MOD: begin
				if (sts.zero_key) begin
					state_d = dhkv_pkg::FSM_DONE;
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = dhkv_pkg::FSM_STEP;
				end
			end
			dhkv_pkg::FSM_STEP: begin
				if (sts.mod_done) begin
					cmd.fix_step = 1'b1;
					state_d      = dhkv_pkg::FSM_READ;
				end
			end
			dhkv_pkg::FSM_READ: begin
				cmd.rd  = 1'b1;
				state_d = dhkv_pkg::FSM_CHECK;
			end
			dhkv_pkg::FSM_CHECK: begin
				if (sts.stop) begin
					cmd.decide = 1'b1;
					state_d    = dhkv_pkg::FSM_WRITE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = dhkv_pkg::FSM_READ;
				end
			end
			dhkv_pkg::FSM_WRITE: begin
				cmd.commit = 1'b1;
				state_d    = dhkv_pkg::FSM_DONE;
			end
			dhkv_pkg::FSM_DONE: begin
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = dhkv_pkg::FSM_IDLE;
				end
			end
			default: state_d = dhkv_pkg::FSM_IDLE;
		endcase
	end

	// Assertions
	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready |-> state_q == dhkv_pkg::FSM_IDLE)) else $error("accept outside idle");
	ap_commit_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide |=> cmd.commit)) else $error("decide not followed by commit");
	ap_load_then_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load |=> state_q == dhkv_pkg::FSM_MOD)) else $error("load lost");

endmodule

// ===== rtl/core/dhkv_dp.sv =====
`timescale 1ns / 1ps
// Datapath: hashing, slot memories, probe walk and result register.
module dhkv_dp #(
	parameter int unsigned CAPACITY = 1024,
	parameter int unsigned KEY_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dhkv_pkg::dhkv_cmd_t cmd,
	output dhkv_pkg::dhkv_sts_t sts,
	input  logic [1:0]         operation,
	input  logic [31:0]        key,
	input  logic [31:0]        value,
	input  logic [9:0]         size_cfg,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic               found,
	output logic [31:0]        result_value
);

	localparam int unsigned AW  = $clog2(CAPACITY);
	localparam int unsigned SW  = $clog2(CAPACITY + 1);
	localparam int unsigned KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int unsigned CW  = SW + 1;

	// Memories
	logic [1:0]    tag_mem [CAPACITY];
	logic [KW-1:0] key_mem [CAPACITY];
	logic [31:0]   val_mem [CAPACITY];

	logic [AW-1:0] clr_q;
	logic [1:0]    op_q;
	logic [KW-1:0] key_q;
	logic [31:0]   val_q;
	logic [SW-1:0] size_q;
	logic [SW-1:0] h_q, step_q, n_q;
	logic [1:0]    tag_rd;
	logic [KW-1:0] key_rd;
	logic [31:0]   val_rd;
	logic          hit_q, have_tomb_q, have_empty_q;
	logic [AW-1:0] hit_slot_q, tomb_slot_q, empty_slot_q;
	logic [CW-1:0] used_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0]    wr_tag;
	logic          wr_kv, wr_v;
	logic [1:0]    res_st;
	logic          res_fnd;
	logic [31:0]   res_rv;
	logic [1:0]    res_st_q;
	logic          res_fnd_q;
	logic [31:0]   res_rv_q;

	logic          mod_done;
	logic [SW-1:0] mod_rem;
	logic [31:0]   size_wide;
	logic [SW-1:0] size_eff;
	logic [SW:0]   h_sum;
	logic [SW:0]   home_sum;
	logic          is_hit;

	// Clamp configured size
	assign size_wide = 32'(size_cfg);
	always_comb begin
		if (size_wide < 32'(dhkv_pkg::MIN_SIZE)) begin
			size_eff = SW'(dhkv_pkg::MIN_SIZE);
		end else if (size_wide > 32'(CAPACITY)) begin
			size_eff = SW'(CAPACITY);
		end else begin
			size_eff = SW'(size_cfg);
		end
	end

	// One remainder of key>>3; the home slot follows from it as 2r + key[2]
	dhkv_mod #(.NUM_W(KW), .DEN_W(SW)) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mod_start),
		.num   (key_q >> 3),
		.den   (size_q),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	assign home_sum = {mod_rem, key_q[2]};

	assign sts.mod_done   = mod_done;
	assign sts.zero_key   = (key_q == '0);
	assign sts.clear_last = (clr_q == AW'(CAPACITY - 1));

	assign h_sum  = {1'b0, h_q} + {1'b0, step_q};
	assign is_hit = (tag_rd == dhkv_pkg::TAG_USED) && (key_rd == key_q);
	assign sts.stop = (tag_rd == dhkv_pkg::TAG_EMPTY) || is_hit || (n_q == size_q - 1'b1);

	// Operand capture, hash and probe walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			key_q  <= KW'(key);
			val_q  <= value;
			size_q <= size_eff;
		end
		if (cmd.fix_step) begin
			n_q <= '0;
			if (home_sum >= {1'b0, size_q}) begin
				h_q <= SW'(home_sum - {1'b0, size_q});
			end else begin
				h_q <= SW'(home_sum);
			end
			if (mod_rem == '0) begin
				step_q <= SW'(2);
			end else if (mod_rem[0]) begin
				step_q <= mod_rem + 1'b1;
			end else begin
				step_q <= mod_rem;
			end
		end
		if (cmd.advance) begin
			n_q <= n_q + 1'b1;
			if (h_sum >= {1'b0, size_q}) begin
				h_q <= SW'(h_sum - {1'b0, size_q});
			end else begin
				h_q <= SW'(h_sum);
			end
		end
	end

	// Chain findings
	always_ff @(posedge clk) begin
		if (cmd.fix_step) begin
			have_tomb_q <= 1'b0;
		end else if (cmd.advance && tag_rd == dhkv_pkg::TAG_GONE && !have_tomb_q) begin
			have_tomb_q <= 1'b1;
			tomb_slot_q <= AW'(h_q);
		end else if (cmd.decide && !is_hit && tag_rd == dhkv_pkg::TAG_GONE && !have_tomb_q) begin
			have_tomb_q <= 1'b1;
			tomb_slot_q <= AW'(h_q);
		end
		if (cmd.decide) begin
			hit_q        <= is_hit;
			hit_slot_q   <= AW'(h_q);
			have_empty_q <= (tag_rd == dhkv_pkg::TAG_EMPTY);
			empty_slot_q <= AW'(h_q);
		end
	end

	// Memory ports: registered read, single write
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			tag_rd <= tag_mem[AW'(h_q)];
			key_rd <= key_mem[AW'(h_q)];
			val_rd <= val_mem[AW'(h_q)];
		end
		if (cmd.clear_wr) begin
			tag_mem[clr_q] <= dhkv_pkg::TAG_EMPTY;
		end else if (cmd.commit && wr_en) begin
			tag_mem[wr_addr] <= wr_tag;
		end
		if (cmd.commit && wr_kv) begin
			key_mem[wr_addr] <= key_q;
		end
		if (cmd.commit && wr_v) begin
			val_mem[wr_addr] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Outcome from findings (valid in write state)
	always_comb begin
		wr_en   = 1'b0;
		wr_kv   = 1'b0;
		wr_v    = 1'b0;
		wr_addr = hit_slot_q;
		wr_tag  = dhkv_pkg::TAG_USED;
		res_st  = dhkv_pkg::ST_NOT_FND;
		res_fnd = 1'b0;
		res_rv  = '0;
		case (op_q)
			dhkv_pkg::OP_INSERT: begin
				if (hit_q) begin
					wr_v    = 1'b1;
					res_st  = dhkv_pkg::ST_OK;
					res_fnd = 1'b1;
					res_rv  = val_q;
				end else if (have_tomb_q) begin
					wr_en   = 1'b1;
					wr_kv   = 1'b1;
					wr_v    = 1'b1;
					wr_addr = tomb_slot_q;
					res_st  = dhkv_pkg::ST_OK;
					res_rv  = val_q;
				end else if (have_empty_q && ({used_q, 1'b0} < (CW+1)'(size_q))) begin
					wr_en   = 1'b1;
					wr_kv   = 1'b1;
					wr_v    = 1'b1;
					wr_addr = empty_slot_q;
					res_st  = dhkv_pkg::ST_OK;
					res_rv  = val_q;
				end else begin
					res_st = dhkv_pkg::ST_FULL;
				end
			end
			dhkv_pkg::OP_DELETE: begin
				if (hit_q) begin
					wr_en   = 1'b1;
					wr_tag  = dhkv_pkg::TAG_GONE;
					res_st  = dhkv_pkg::ST_OK;
					res_fnd = 1'b1;
				end
			end
			default: begin
				if (hit_q) begin
					res_st  = dhkv_pkg::ST_OK;
					res_fnd = 1'b1;
					res_rv  = val_rd;
				end
			end
		endcase
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit && wr_en && wr_tag == dhkv_pkg::TAG_USED
				&& !have_tomb_q) begin
			used_q <= used_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_st_q  <= res_st;
			res_fnd_q <= res_fnd;
			res_rv_q  <= res_rv;
		end
		if (cmd.out_load) begin
			if (key_q == '0) begin
				status       <= dhkv_pkg::ST_ZERO_KEY;
				found        <= 1'b0;
				result_value <= '0;
			end else begin
				status       <= res_st_q;
				found        <= res_fnd_q;
				result_value <= res_rv_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Assertions
	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q <= CW'(CAPACITY))) else $error("fill count overflow");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready |=> out_valid)) else $error("result dropped");
	ap_no_write_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear_wr |-> !cmd.commit)) else $error("write during clear");

endmodule

// ===== rtl/core/double_hash_key_value_map_unit.sv =====
`timescale 1ns / 1ps
// Top level of the double hash key/value map.
// Usage:
// - in channel (in_valid/in_ready) carries operation, key, value.
// - out channel (out_valid/out_ready) carries status, found, result_value.
// - cfg channel (cfg_valid/cfg_ready) writes table_size; write only when idle.
// After reset a clearing pass marks every slot empty; no item is accepted
// during it, configuration transfers still are.
// The steps of an item after the input transfer: the controller starts the
// bit-serial remainder of key>>3 (KW bits, KW being the hashed key width,
// 32 by default), sets the step and home slot once it is done, then for
// each probed slot reads it through the registered memory read and checks
// it, passes the write state and loads the result register. The next item
// is taken once the controller is back in idle.
// A zero key skips hashing and probing and goes straight to the result.
// One item is in flight at a time; the result waits in the output
// register while the receiver stalls, and the next item then holds in the
// controller until that register frees, keeping in_ready low.
module double_hash_key_value_map_unit #(
	parameter int unsigned CAPACITY = 1024,
	parameter int unsigned KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] result_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  table_size
);

	dhkv_pkg::dhkv_cmd_t cmd;
	dhkv_pkg::dhkv_sts_t sts;
	logic                idle;
	logic [9:0]          size_q;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 10'd7;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= table_size;
		end
	end

	dhkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	dhkv_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.key         (key),
		.value       (value),
		.size_cfg    (size_q),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.found       (found),
		.result_value(result_value)
	);

	ap_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid |-> idle)) else $error("cfg while busy");
	ap_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready |=> $stable(status) && $stable(found)
		&& $stable(result_value))) else $error("result changed while waiting");
	ap_size_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg_valid |=> $stable(size_q))) else $error("size changed without write");

endmodule
